// ===== hw/rtl/mss_pkg.sv =====
// types and constants shared by the motion safety supervisor and its checker
package mss_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned OpW    = 3;
  localparam int unsigned FlagW  = 11;
  localparam int unsigned FaultW = 12;

  // operating modes
  localparam logic [ModeW-1:0] MODE_BOOT      = 3'd0;
  localparam logic [ModeW-1:0] MODE_SELF_TEST = 3'd1;
  localparam logic [ModeW-1:0] MODE_STANDBY   = 3'd2;
  localparam logic [ModeW-1:0] MODE_ARMED     = 3'd3;
  localparam logic [ModeW-1:0] MODE_ACTIVE    = 3'd4;
  localparam logic [ModeW-1:0] MODE_CSTOP     = 3'd5;
  localparam logic [ModeW-1:0] MODE_LATCHED   = 3'd6;
  localparam logic [ModeW-1:0] MODE_FWUPD     = 3'd7;

  // command opcodes
  localparam logic [OpW-1:0] OP_BEGIN_TEST  = 3'd0;
  localparam logic [OpW-1:0] OP_FINISH_TEST = 3'd1;
  localparam logic [OpW-1:0] OP_ARM         = 3'd2;
  localparam logic [OpW-1:0] OP_ACTIVATE    = 3'd3;
  localparam logic [OpW-1:0] OP_DISARM      = 3'd4;
  localparam logic [OpW-1:0] OP_FW_UPDATE   = 3'd5;
  localparam logic [OpW-1:0] OP_EVALUATE    = 3'd6;
  localparam logic [OpW-1:0] OP_CLEAR       = 3'd7;

  // fault bit positions
  localparam int unsigned FaultEstop    = 0;
  localparam int unsigned FaultCmdStale = 1;
  localparam int unsigned FaultRunaway  = 8;
  localparam int unsigned FaultSelfTest = 11;

  // faults that latch, and faults that force the bridge off
  localparam logic [FaultW-1:0] LATCH_MASK     = 12'hB79;
  localparam logic [FaultW-1:0] IMMEDIATE_MASK = 12'hB79;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [FlagW-1:0] health_flags;
    logic             self_test_passed;
    logic             physical_ack;
  } mss_in_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [FaultW-1:0] active_fault_mask;
    logic [FaultW-1:0] latched_fault_mask;
    logic              accepted;
    logic              motion_allowed;
    logic              bridge_disable;
  } mss_out_t;

endpackage

// ===== hw/rtl/motion_safety_supervisor.sv =====
// motion safety supervisor: mode and fault mask update, one command per cycle unless the output stalls
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (mss_in_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (mss_out_t)
//
// a command is registered on acceptance, then evaluated as it leaves the input stage,
// where the mode and fault masks update and the result register loads.
// the result is registered in the output stage; one command per cycle unless the output stalls.
// reset puts the mode in boot with both masks clear and both stages empty.
// a stall on the output holds the result and backs up into the input stage.
module motion_safety_supervisor
  import mss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mss_out_t out_data_o
);

  logic              in_vld_q;
  mss_in_t           in_q;
  logic              out_vld_q;
  mss_out_t          out_q;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic [FaultW-1:0] act_q, act_d;
  logic [FaultW-1:0] lat_q, lat_d;
  logic              accepted;
  logic              clean;
  logic              advance;
  logic [FaultW-1:0] eval_faults;
  logic              unsafe_mode;
  mss_out_t          res;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign clean      = (act_q == '0) && (lat_q == '0);

  // fault bits from the health flags; estop and runaway are bad when set
  always_comb begin
    eval_faults = {1'b0, ~in_q.health_flags};
    eval_faults[FaultEstop]   = in_q.health_flags[FaultEstop];
    eval_faults[FaultRunaway] = in_q.health_flags[FaultRunaway];
    // stale command only counts while motion is commanded
    if (mode_q != MODE_ACTIVE && mode_q != MODE_CSTOP) begin
      eval_faults[FaultCmdStale] = 1'b0;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    act_d    = act_q;
    lat_d    = lat_q;
    accepted = 1'b1;
    unique case (in_q.opcode)
      OP_BEGIN_TEST: begin
        if (mode_q == MODE_BOOT) mode_d = MODE_SELF_TEST;
      end
      OP_FINISH_TEST: begin
        if (mode_q != MODE_SELF_TEST || !in_q.self_test_passed) begin
          act_d[FaultSelfTest] = 1'b1;
          lat_d[FaultSelfTest] = LATCH_MASK[FaultSelfTest];
        end else begin
          mode_d = MODE_STANDBY;
        end
      end
      OP_ARM: begin
        if (mode_q == MODE_STANDBY && clean) mode_d = MODE_ARMED;
        else accepted = 1'b0;
      end
      OP_ACTIVATE: begin
        if (mode_q == MODE_ARMED && clean) mode_d = MODE_ACTIVE;
        else accepted = 1'b0;
      end
      OP_DISARM: begin
        if (mode_q != MODE_FWUPD) mode_d = MODE_STANDBY;
      end
      OP_FW_UPDATE: begin
        if (mode_q == MODE_STANDBY && act_q == '0) mode_d = MODE_FWUPD;
      end
      OP_EVALUATE: begin
        act_d = eval_faults;
        lat_d = lat_q | (eval_faults & LATCH_MASK);
        priority if (lat_d != '0) begin
          mode_d = MODE_LATCHED;
        end else if (eval_faults != '0) begin
          if (mode_q == MODE_ACTIVE || mode_q == MODE_ARMED) mode_d = MODE_CSTOP;
        end else if (mode_q == MODE_CSTOP) begin
          mode_d = MODE_STANDBY;
        end
      end
      OP_CLEAR: begin
        if (in_q.physical_ack && act_q == '0) begin
          lat_d  = '0;
          mode_d = MODE_STANDBY;
        end else begin
          accepted = 1'b0;
        end
      end
      default: begin
        accepted = 1'b1;
      end
    endcase
  end

  assign unsafe_mode = (mode_d == MODE_BOOT) || (mode_d == MODE_SELF_TEST) ||
                       (mode_d == MODE_STANDBY) || (mode_d == MODE_LATCHED) ||
                       (mode_d == MODE_FWUPD);

  always_comb begin
    res.mode               = mode_d;
    res.active_fault_mask  = act_d;
    res.latched_fault_mask = lat_d;
    res.accepted           = accepted;
    res.motion_allowed     = (mode_d == MODE_ACTIVE) && (act_d == '0) && (lat_d == '0);
    res.bridge_disable     = unsafe_mode || (((act_d | lat_d) & IMMEDIATE_MASK) != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_BOOT;
      act_q     <= '0;
      lat_q     <= '0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= 1'b1;
        mode_q    <= mode_d;
        act_q     <= act_d;
        lat_q     <= lat_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
    if (advance) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/mss_checker.sv =====
// port-level assertions for the motion safety supervisor, bound to the supervisor module
module mss_checker
  import mss_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input mss_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input mss_out_t out_data_o
);

  // a stalled command transaction holds on the input
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled command changed");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_motion_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.motion_allowed |->
      out_data_o.mode == MODE_ACTIVE && out_data_o.active_fault_mask == '0 &&
      out_data_o.latched_fault_mask == '0)
    else $error("motion permitted outside clean active mode");

  a_motion_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.motion_allowed |-> !out_data_o.bridge_disable)
    else $error("motion permitted with bridge disabled");

  // every latching fault is also an immediate-disable fault
  a_latched_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.latched_fault_mask != '0 |-> out_data_o.bridge_disable)
    else $error("latched fault without bridge disable");

endmodule

bind motion_safety_supervisor mss_checker u_mss_checker (.*);
